// ----- rtl/lwct_pkg.sv -----
// ----------------------------------------------------------------------------
// lwct_pkg: shared types and constants
// Field structs, register indexes, fixed-point constants and the command and
// status groups used between the controller and the datapath.
// ----------------------------------------------------------------------------
package lwct_pkg;

    localparam int MAX_LEGS = 4;
    localparam int CNT_W    = $clog2(MAX_LEGS + 1);

    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [16:0] LOAD_SWING_MIN = 17'd52429;

    localparam logic [2:0] REG_MIN_W   = 3'd0;
    localparam logic [2:0] REG_STANCE  = 3'd1;
    localparam logic [2:0] REG_SWING   = 3'd2;
    localparam logic [2:0] REG_HEADING = 3'd3;
    localparam logic [2:0] REG_LATERAL = 3'd4;

    // Divider width: dividends are at most 52 bits of magnitude.
    localparam int DIV_W = 53;

    typedef struct packed {
        logic               is_support;
        logic               must_ground;
        logic        [16:0] swing_phase;
        logic        [16:0] stance_phase;
        logic signed [31:0] foot_x;
        logic signed [31:0] foot_y;
        logic               last_leg;
    } leg_in_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } target_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // load the input item
        logic ramp_start;  // start the ramp division
        logic weight;      // form the leg weight from the ramp quotient
        logic mult;        // multiply positions by weight
        logic accum;       // add into the sums
        logic mean_start;  // start the mean division for axis sel_y
        logic sel_y;
        logic store_mean;  // latch the saturated mean for axis sel_y
        logic clear;       // clear the sums
    } lwct_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last;
        logic full;
    } lwct_sts_t;

endpackage

// ----- rtl/lwct_divider.sv -----
// ----------------------------------------------------------------------------
// lwct_divider: shared restoring divider
// Unsigned magnitude division, one quotient bit per cycle, with sign fix-up
// for truncation toward zero.
// ----------------------------------------------------------------------------
module lwct_divider import lwct_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic        [19:0]      divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient
);
    localparam int BIT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [20:0]      r_reg, r_next;
    logic [19:0]      d_reg;
    logic             neg_reg;
    logic [BIT_W-1:0] bits_reg;
    logic             busy_reg;
    logic [21:0]      trial;
    logic [20:0]      shifted;

    always_comb begin
        shifted = {r_reg[19:0], q_reg[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b0, d_reg};
        q_next  = {q_reg[DIV_W-2:0], ~trial[21]};
        r_next  = trial[21] ? shifted : trial[20:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                bits_reg <= BIT_W'(DIV_W);
                q_reg    <= dividend[DIV_W-1] ? -dividend : dividend;
                neg_reg  <= dividend[DIV_W-1];
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                q_reg    <= q_next;
                r_reg    <= r_next;
                bits_reg <= bits_reg - 1'b1;
                if (bits_reg == BIT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

// ----- rtl/lwct_datapath.sv -----
// ----------------------------------------------------------------------------
// lwct_datapath: weight, sums and mean
// Holds the configuration, the current leg, the running sums and the result.
// ----------------------------------------------------------------------------
module lwct_datapath import lwct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  leg_in_t     leg,
    input  lwct_cmd_t   cmd,
    output lwct_sts_t   sts,
    output target_out_t result
);
    logic        [16:0] min_w_reg;
    logic        [15:0] stance_a_reg, swing_a_reg;
    logic signed [31:0] head_reg, lat_reg;

    leg_in_t            leg_reg;
    logic               loaded_reg;
    logic               ramp_sat_reg; // ramp pinned at 0 or one
    logic        [16:0] ramp_fix_reg;
    logic        [16:0] w_reg;
    logic signed [51:0] px_reg, py_reg;

    logic signed [51:0] wsx_reg, wsy_reg;
    logic        [19:0] wt_reg;
    logic signed [34:0] psx_reg, psy_reg;
    logic [CNT_W-1:0]   legs_reg;

    logic                    div_start, div_done;
    logic signed [DIV_W-1:0] div_num, div_q;
    logic        [19:0]      div_den;

    logic        [16:0] v_sel;
    logic        [16:0] a_sel;
    logic        [16:0] ramp_q;
    logic        [16:0] t_val;
    logic        [16:0] m_eff;
    logic        [33:0] blend_prod;
    logic signed [DIV_W:0] mean_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_w_reg    <= '0;
            stance_a_reg <= '0;
            swing_a_reg  <= '0;
            head_reg     <= '0;
            lat_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_W:   min_w_reg    <= cfg_data[16:0];
                REG_STANCE:  stance_a_reg <= cfg_data[15:0];
                REG_SWING:   swing_a_reg  <= cfg_data[15:0];
                REG_HEADING: head_reg     <= cfg_data;
                REG_LATERAL: lat_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    wire loaded_now = leg.must_ground ||
                      (leg.is_support && leg.swing_phase >= LOAD_SWING_MIN);

    always_comb begin
        v_sel = loaded_reg ? leg_reg.stance_phase : leg_reg.swing_phase;
        a_sel = {1'b0, loaded_reg ? stance_a_reg : swing_a_reg};
    end

    assign ramp_q = ramp_sat_reg ? ramp_fix_reg : div_q[16:0];
    assign t_val  = loaded_reg ? ONE_Q16 - ramp_q : ramp_q;
    assign m_eff  = (min_w_reg > ONE_Q16) ? ONE_Q16 : min_w_reg;
    assign blend_prod = (ONE_Q16 - m_eff) * t_val;

    always_comb begin
        div_start = cmd.ramp_start | cmd.mean_start;
        div_num   = '0;
        div_den   = '0;
        if (cmd.ramp_start) begin
            div_num = DIV_W'({v_sel - a_sel, 16'b0});
            div_den = 20'(ONE_Q16 - a_sel);
        end else if (wt_reg != 20'd0) begin
            div_num = DIV_W'(cmd.sel_y ? wsy_reg : wsx_reg);
            div_den = wt_reg;
        end else begin
            div_num = DIV_W'(cmd.sel_y ? psy_reg : psx_reg);
            div_den = (legs_reg == '0) ? 20'd1 : 20'(legs_reg);
        end
    end

    lwct_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mean_sum = (DIV_W+1)'(div_q) +
                      (DIV_W+1)'(cmd.sel_y ? lat_reg : head_reg);

    function automatic logic [31:0] sat32(input logic signed [DIV_W:0] v);
        if (v > (DIV_W+1)'(64'sd2147483647))       return 32'h7FFF_FFFF;
        else if (v < -(DIV_W+1)'(64'sd2147483648)) return 32'h8000_0000;
        else                                        return v[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            leg_reg    <= leg;
            loaded_reg <= loaded_now;
        end
        if (cmd.ramp_start) begin
            ramp_sat_reg <= (v_sel <= a_sel) || (v_sel >= ONE_Q16);
            ramp_fix_reg <= (v_sel <= a_sel) ? 17'd0 : ONE_Q16;
        end
        if (cmd.weight)
            w_reg <= m_eff + blend_prod[32:16];
        if (cmd.mult) begin
            px_reg <= 52'(leg_reg.foot_x * $signed({1'b0, w_reg}));
            py_reg <= 52'(leg_reg.foot_y * $signed({1'b0, w_reg}));
        end
        if (cmd.store_mean) begin
            if (cmd.sel_y) result.target_y <= sat32(mean_sum);
            else           result.target_x <= sat32(mean_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            wsx_reg  <= '0;
            wsy_reg  <= '0;
            wt_reg   <= '0;
            psx_reg  <= '0;
            psy_reg  <= '0;
            legs_reg <= '0;
        end else if (cmd.accum) begin
            wsx_reg  <= wsx_reg + px_reg;
            wsy_reg  <= wsy_reg + py_reg;
            wt_reg   <= wt_reg + 20'(w_reg);
            psx_reg  <= psx_reg + 35'(leg_reg.foot_x);
            psy_reg  <= psy_reg + 35'(leg_reg.foot_y);
            legs_reg <= legs_reg + 1'b1;
        end
    end

    assign sts.div_done = div_done;
    assign sts.last     = leg_reg.last_leg;
    assign sts.full     = (legs_reg == CNT_W'(MAX_LEGS));
endmodule

// ----- rtl/lwct_ctrl.sv -----
// ----------------------------------------------------------------------------
// lwct_ctrl: sequencing state machine
// Steps one leg through ramp division, weighting, multiply and accumulate,
// then on the last leg through the two mean divisions and the result handoff.
// ----------------------------------------------------------------------------
module lwct_ctrl import lwct_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  lwct_sts_t sts,
    output lwct_cmd_t cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_RAMP   = 4'd2;
    localparam logic [3:0] ST_WGT    = 4'd3;
    localparam logic [3:0] ST_MULT   = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_LAST   = 4'd6;
    localparam logic [3:0] ST_DIVX   = 4'd7;
    localparam logic [3:0] ST_DIVY   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_STARTY = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = 1'b1;
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.full) begin
                    state_next = ST_LAST;
                end else begin
                    cmd.ramp_start = 1'b1;
                    state_next     = ST_RAMP;
                end
            end
            ST_RAMP: if (sts.div_done) state_next = ST_WGT;
            ST_WGT: begin
                cmd.weight = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = ST_LAST;
            end
            ST_LAST: begin
                if (sts.last) begin
                    cmd.mean_start = 1'b1;
                    state_next     = ST_DIVX;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVX: begin
                if (sts.div_done) begin
                    cmd.store_mean = 1'b1;
                    state_next     = ST_STARTY;
                end
            end
            ST_STARTY: begin
                cmd.mean_start = 1'b1;
                cmd.sel_y      = 1'b1;
                state_next     = ST_DIVY;
            end
            ST_DIVY: begin
                cmd.sel_y = 1'b1;
                if (sts.div_done) begin
                    cmd.store_mean = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule

// ----- rtl/leg_weighted_com_target.sv -----
// ----------------------------------------------------------------------------
// leg_weighted_com_target: leg-weighted center-of-mass target
// Weights each leg by its gait phase and forms the offset weighted mean of
// the foot positions once per control step.
// ----------------------------------------------------------------------------
// Usage: present one request per leg on s_valid/s_ready with s_data; the leg
// flagged last_leg closes the control step and yields one result request on
// m_valid/m_ready with m_data. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data while the block is idle.
// An ordinary leg passes its weight ramp through the shared 53-step restoring
// divider, followed by weight, multiply and accumulate steps. A last leg adds
// two more passes through that same divider for the x and y means before its
// result is shown; a leg beyond the leg limit skips the ramp and weighting. One
// leg is in work at a time, so s_ready is high only while the block waits for a
// leg.
// A leg beyond the leg limit is not accumulated but still closes the step.
// Reset clears the configuration registers and all sums. When the receiver
// stalls, the result holds on m_data and no new leg is taken until it is
// accepted.
// ----------------------------------------------------------------------------
module leg_weighted_com_target import lwct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  leg_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output target_out_t m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    lwct_cmd_t cmd;
    lwct_sts_t sts;

    // The controller sequences; the datapath holds all arithmetic state.
    lwct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lwct_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .leg       (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (m_data)
    );
endmodule

// ----- tb/leg_weighted_com_target_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_weighted_com_target_tb: self-checking bench for the COM target block
// Drives leg requests from a queue, predicts every target from its own model
// of the weighting and mean arithmetic, and compares each result request in
// order while both sides stall at random.
// ----------------------------------------------------------------------------
module leg_weighted_com_target_tb;
    import lwct_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    leg_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    target_out_t m_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    leg_weighted_com_target dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Predictor state: configuration and running sums, mirrored from the block.
    logic [16:0]        cfg_min_w;
    logic [15:0]        cfg_stance_a;
    logic [15:0]        cfg_swing_a;
    logic signed [31:0] cfg_heading;
    logic signed [31:0] cfg_lateral;
    longint             acc_wx, acc_wy, acc_px, acc_py;
    longint             acc_w;
    int                 acc_legs;

    leg_in_t     leg_queue[$];
    target_out_t target_queue[$];

    int  error_count;
    int  legs_sent;
    int  targets_checked;
    int  idle_cycles;
    bit  send_paused;
    bit  hold_receiver;
    bit  stimulus_done;

    // Clamped ramp (v-a)/(1-a) in Q1.16, truncated.
    function automatic longint phase_ramp(longint v, longint a);
        if (v <= a) return 0;
        if (v >= 65536) return 65536;
        return ((v - a) << 16) / (65536 - a);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Accumulates one leg and, on the last leg, queues the expected target.
    task automatic predict_leg(input leg_in_t leg);
        longint m, t, w, mx, my, n;
        target_out_t tgt;
        if (acc_legs < MAX_LEGS) begin
            m = (cfg_min_w > 17'd65536) ? 65536 : cfg_min_w;
            if ((leg.is_support && leg.swing_phase >= LOAD_SWING_MIN) || leg.must_ground)
                t = 65536 - phase_ramp(leg.stance_phase, cfg_stance_a);
            else
                t = phase_ramp(leg.swing_phase, cfg_swing_a);
            w = m + (((65536 - m) * t) >> 16);
            acc_wx += longint'(leg.foot_x) * w;
            acc_wy += longint'(leg.foot_y) * w;
            acc_w  += w;
            acc_px += longint'(leg.foot_x);
            acc_py += longint'(leg.foot_y);
            acc_legs++;
        end
        if (leg.last_leg) begin
            if (acc_w != 0) begin
                mx = acc_wx / acc_w;
                my = acc_wy / acc_w;
            end else begin
                n = (acc_legs != 0) ? acc_legs : 1;
                mx = acc_px / n;
                my = acc_py / n;
            end
            tgt.target_x = 32'(sat_s32(mx + longint'(cfg_heading)));
            tgt.target_y = 32'(sat_s32(my + longint'(cfg_lateral)));
            target_queue.push_back(tgt);
            acc_wx = 0; acc_wy = 0; acc_w = 0;
            acc_px = 0; acc_py = 0; acc_legs = 0;
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // Driver: one request offered at a time, held until accepted.
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && s_ready) begin
            predict_leg(s_data);
            legs_sent <= legs_sent + 1;
            if (leg_queue.size() != 0 && gap_len() == 0 && !send_paused) begin
                s_data <= leg_queue.pop_front();
            end else begin
                s_valid  <= 1'b0;
                send_gap <= gap_len();
            end
        end else if (!s_valid) begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (leg_queue.size() != 0 && !send_paused) begin
                s_data  <= leg_queue.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // Monitor: random backpressure, with an optional long hold-off.
    int recv_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (target_queue.size() == 0) begin
                    $display("%0t ERROR: unexpected target x=%0d y=%0d",
                             $time, m_data.target_x, m_data.target_y);
                    error_count = error_count + 1;
                end else begin
                    if (m_data.target_x !== target_queue[0].target_x) begin
                        $display("%0t ERROR: target_x expected %0d actual %0d", $time,
                                 target_queue[0].target_x, m_data.target_x);
                        error_count = error_count + 1;
                    end
                    if (m_data.target_y !== target_queue[0].target_y) begin
                        $display("%0t ERROR: target_y expected %0d actual %0d", $time,
                                 target_queue[0].target_y, m_data.target_y);
                        error_count = error_count + 1;
                    end
                    void'(target_queue.pop_front());
                end
                targets_checked <= targets_checked + 1;
            end
            if (hold_receiver) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else if (m_ready && m_valid) begin
                recv_gap <= gap_len();
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles with no accepted request on either channel, outside a receiver hold.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_receiver)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired with %0d targets outstanding",
                     $time, target_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic leg_in_t random_leg(bit last);
        leg_in_t leg;
        int sel;
        leg.is_support  = 1'($urandom_range(0, 1));
        leg.must_ground = ($urandom_range(0, 3) == 0);
        // Phases mostly in range, sometimes exactly one or beyond it.
        sel = $urandom_range(0, 9);
        leg.swing_phase  = (sel == 0) ? 17'($urandom) : (sel == 1) ? 17'd65536
                           : 17'($urandom_range(0, 65536));
        sel = $urandom_range(0, 9);
        leg.stance_phase = (sel == 0) ? 17'($urandom) : (sel == 1) ? 17'd65536
                           : 17'($urandom_range(0, 65536));
        sel = $urandom_range(0, 9);
        leg.foot_x = (sel == 0) ? 32'sh7fffffff : (sel == 1) ? 32'sh80000000
                     : (sel < 5) ? 32'($urandom) : 32'($signed($urandom_range(0, 400000)) - 200000);
        sel = $urandom_range(0, 9);
        leg.foot_y = (sel == 0) ? 32'sh7fffffff : (sel == 1) ? 32'sh80000000
                     : (sel < 5) ? 32'($urandom) : 32'($signed($urandom_range(0, 400000)) - 200000);
        leg.last_leg = last;
        return leg;
    endfunction

    // Queues one control step of legs; the count sometimes exceeds the leg limit.
    task automatic queue_step(int legs);
        for (int i = 0; i < legs; i++)
            leg_queue.push_back(random_leg(i == legs - 1));
    endtask

    task automatic wait_idle();
        while (leg_queue.size() != 0 || s_valid || target_queue.size() != 0)
            @(posedge aclk);
        // A leg that closes nothing may still be in work inside the block.
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_W:   cfg_min_w    = value[16:0];
            REG_STANCE:  cfg_stance_a = value[15:0];
            REG_SWING:   cfg_swing_a  = value[15:0];
            REG_HEADING: cfg_heading  = value;
            REG_LATERAL: cfg_lateral  = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] mw, logic [31:0] sa, logic [31:0] wa,
                             logic [31:0] ho, logic [31:0] lo);
        write_reg(REG_MIN_W, mw);
        write_reg(REG_STANCE, sa);
        write_reg(REG_SWING, wa);
        write_reg(REG_HEADING, ho);
        write_reg(REG_LATERAL, lo);
    endtask

    task automatic push_leg(int sup, int gnd, int sw, int st, int fx, int fy, int last);
        leg_in_t leg;
        leg.is_support = sup[0]; leg.must_ground = gnd[0];
        leg.swing_phase = 17'(sw); leg.stance_phase = 17'(st);
        leg.foot_x = fx; leg.foot_y = fy; leg.last_leg = last[0];
        leg_queue.push_back(leg);
    endtask

    int phase;
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0; legs_sent = 0; targets_checked = 0; idle_cycles = 0;
        send_paused = 1'b0; hold_receiver = 1'b0; stimulus_done = 1'b0;
        cfg_min_w = '0; cfg_stance_a = '0; cfg_swing_a = '0;
        cfg_heading = '0; cfg_lateral = '0;
        acc_wx = 0; acc_wy = 0; acc_w = 0; acc_px = 0; acc_py = 0; acc_legs = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from reset values: every weight is zero,
        // so the plain mean is taken.
        push_leg(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
        push_leg(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 1);
        // Single last leg, a leg alone closing a step.
        push_leg(1, 1, 65536, 65536, -5, 7, 1);
        wait_idle();
        // Weight floor above one, large offsets to force saturation.
        write_all(32'h1ffff, 32'd0, 32'd0, 32'h7fffffff, 32'h80000000);
        push_leg(1, 0, 52429, 100, 32'h7fffffff, 32'h80000000, 0);
        push_leg(1, 0, 52428, 100, 1000, -1000, 1);
        wait_idle();
        // Ramps near their ends; phases above one; too many legs in a step.
        write_all(32'd0, 32'd65535, 32'd65535, 32'd0, 32'd0);
        push_leg(0, 1, 65535, 131071, 12345, -54321, 0);
        push_leg(0, 0, 131071, 65535, -999999, 888888, 0);
        push_leg(1, 0, 52429, 0, 3, 4, 0);
        push_leg(0, 0, 65536, 0, 32'h80000000, 32'h7fffffff, 0);
        push_leg(0, 0, 65536, 0, 77, 77, 0);
        push_leg(1, 1, 0, 0, 99, 99, 1);
        wait_idle();
        write_all(32'd65536, 32'd32768, 32'd16384, 32'hfff00000, 32'h00100000);
        push_leg(0, 0, 40000, 30000, 65536, -65536, 0);
        push_leg(1, 1, 20000, 50000, -65536, 65536, 1);
        wait_idle();

        // Random phases, each with its own configuration.
        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: write_all($urandom_range(0, 65536), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom, $urandom);
                1: write_all($urandom_range(0, 8000), $urandom_range(0, 40000),
                             $urandom_range(0, 40000), $urandom_range(0, 2000) - 1000,
                             $urandom_range(0, 2000) - 1000);
                2: write_all(32'd0, 32'd65535, 32'd0, 32'h7fffffff, 32'h80000000);
                default: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            // Mostly well-formed steps of one to the leg limit, some overlong.
            while (leg_queue.size() < 105)
                queue_step(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(1, MAX_LEGS));
            if (phase == 3) begin
                // The receiver holds off while legs keep coming.
                hold_receiver = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            if (phase == 6) begin
                while (leg_queue.size() > 50) @(posedge aclk);
                // The sender pauses until every target has come back.
                send_paused = 1'b1;
                while (target_queue.size() != 0) @(posedge aclk);
                send_paused = 1'b0;
            end
            wait_idle();
        end
        stimulus_done = 1'b1;

        $display("Sent %0d legs and checked %0d targets over 16 register settings,",
                 legs_sent, targets_checked);
        $display("including weight floor, saturation, zero-weight and overlong steps.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
